[rtl/core/page_framebuffer_refresh_defines.svh]
// Assertion macros shared by the checker files.
// Each macro expects a clock named clk and an active low reset named rst_n in scope.
`ifndef PAGE_FRAMEBUFFER_REFRESH_DEFINES_SVH
`define PAGE_FRAMEBUFFER_REFRESH_DEFINES_SVH

// Same-cycle implication.
`define PFR_ASSERT_IMPLY(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define PFR_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/core/pfr_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package pfr_pkg;

    localparam int WIDTH     = 128;
    localparam int PAGES     = 8;
    localparam int CMD_COUNT = 4;
    localparam int DEPTH     = WIDTH * PAGES;
    localparam int ADDR_W    = $clog2(DEPTH);
    localparam int POS_W     = $clog2(WIDTH + CMD_COUNT);
    localparam int PAGE_W    = (PAGES > 1) ? $clog2(PAGES) : 1;
    localparam int ROW_LIMIT = PAGES * 8;

    // 7-p is taken in three bits
    localparam int PAGE_FIELD_W = 3;
    localparam logic [PAGE_FIELD_W-1:0] PAGE_TOP = 3'd7;

    localparam logic [7:0] NIBBLE_MASK = 8'h0F;

    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_START_COLUMN     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PAGE_CMD_BASE    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_COL_LOW_CMD_BASE = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_COL_HI_CMD_BASE  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_RMW_CMD          = 3'd4;

    localparam logic [7:0] RST_START_COLUMN     = 8'd0;
    localparam logic [7:0] RST_PAGE_CMD_BASE    = 8'd176;
    localparam logic [7:0] RST_COL_LOW_CMD_BASE = 8'd0;
    localparam logic [7:0] RST_COL_HI_CMD_BASE  = 8'd16;
    localparam logic [7:0] RST_RMW_CMD          = 8'd224;

    // stream positions inside a page
    localparam logic [POS_W-1:0] POS_PAGE_CMD    = POS_W'(0);
    localparam logic [POS_W-1:0] POS_COL_LOW_CMD = POS_W'(1);
    localparam logic [POS_W-1:0] POS_COL_HI_CMD  = POS_W'(2);
    localparam logic [POS_W-1:0] POS_RMW_CMD     = POS_W'(3);
    localparam logic [POS_W-1:0] POS_LAST        = POS_W'(CMD_COUNT + WIDTH - 1);

    typedef struct packed {
        logic [7:0] out_byte;
        logic       is_data;
        logic       frame_last;
    } result_t;

endpackage

`default_nettype wire

[rtl/core/pfr_ifs.sv]
`timescale 1ns / 1ps
`default_nettype none

interface pfr_item_if;
    logic       valid;
    logic       ready;
    logic       action;
    logic [7:0] pixel_x;
    logic [7:0] pixel_y;
    logic       pixel_on;

    modport source (output valid, action, pixel_x, pixel_y, pixel_on, input ready);
    modport sink   (input valid, action, pixel_x, pixel_y, pixel_on, output ready);
endinterface

interface pfr_result_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       is_data;
    logic       frame_last;

    modport source (output valid, out_byte, is_data, frame_last, input ready);
    modport sink   (input valid, out_byte, is_data, frame_last, output ready);
endinterface

interface pfr_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [pfr_pkg::CFG_IDX_W-1:0] index;
    logic [7:0]                    data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

[rtl/core/page_framebuffer_refresh.sv]
`timescale 1ns / 1ps
`default_nettype none

// Monochrome page frame store with a panel refresh stream.
// item   : request channel. action 0 writes one pixel (pixel_x, pixel_y, pixel_on),
//          action 1 asks for the next byte of the controller stream.
// result : one byte per stream request (out_byte, is_data, frame_last); pixel
//          writes produce nothing. Each page sends four command bytes (page,
//          column low, column high, read-modify-write) then WIDTH data bytes.
// cfg    : register writes (index, data), always ready; write only while idle.
// Flow   : every request goes through the single port frame memory:
//          the accept cycle issues the read, the next cycle either writes the
//          modified byte back or loads the result register. A new request is
//          taken only once the last is through. A stream byte is shown from the result register.
// Reset  : a clearing pass zeroes the 1024 byte store, one byte per cycle;
//          item.ready stays low meanwhile, cfg writes still land.
// Stall  : the result register holds its byte while result.ready is low; a new
//          request is taken only when that register is empty or being drained.
module page_framebuffer_refresh (
    input  wire           clk,
    input  wire           rst_n,
    pfr_item_if.sink      item,
    pfr_result_if.source  result,
    pfr_cfg_if.sink       cfg
);

    localparam logic [1:0] S_CLEAR = 2'd0;
    localparam logic [1:0] S_IDLE  = 2'd1;
    localparam logic [1:0] S_PIX   = 2'd2;
    localparam logic [1:0] S_EMIT  = 2'd3;

    logic [1:0] state_reg, state_next;

    // configuration registers
    logic [7:0] start_column_reg;
    logic [7:0] page_cmd_base_reg;
    logic [7:0] col_low_cmd_base_reg;
    logic [7:0] col_hi_cmd_base_reg;
    logic [7:0] rmw_cmd_reg;

    // refresh walk
    logic [pfr_pkg::PAGE_W-1:0] page_reg, page_next;
    logic [pfr_pkg::POS_W-1:0]  pos_reg, pos_next;

    // clearing pass
    logic [pfr_pkg::ADDR_W-1:0] clr_addr_reg;

    // request held for the S_PIX or S_EMIT state
    logic [pfr_pkg::ADDR_W-1:0] pix_addr_reg;
    logic                       pix_ok_reg;
    logic [7:0]                 pix_mask_reg;
    logic                       pix_on_reg;
    logic [7:0]                 cmd_byte_reg;
    logic                       emit_data_reg;
    logic                       emit_last_reg;

    // result register
    logic                result_valid_reg;
    pfr_pkg::result_t    result_reg;

    // frame memory
    logic [7:0]                 frame_mem [pfr_pkg::DEPTH];
    logic [7:0]                 rd_data_reg;
    logic [pfr_pkg::ADDR_W-1:0] rd_addr;
    logic                       mem_we;
    logic [pfr_pkg::ADDR_W-1:0] wr_addr;
    logic [7:0]                 wr_data;

    logic                       accept;
    logic                       pix_in_range;
    logic [pfr_pkg::ADDR_W-1:0] pix_addr;
    logic [7:0]                 pix_mask;
    logic [pfr_pkg::ADDR_W-1:0] data_addr;
    logic [7:0]                 cmd_byte;
    logic                       wrap_page;
    logic                       frame_end;

    assign accept = item.valid && item.ready;

    // take a request only when idle and the result slot is free or draining
    assign item.ready = (state_reg == S_IDLE) && (!result_valid_reg || result.ready);
    assign cfg.ready  = 1'b1;

    assign result.valid      = result_valid_reg;
    assign result.out_byte   = result_reg.out_byte;
    assign result.is_data    = result_reg.is_data;
    assign result.frame_last = result_reg.frame_last;

    // pixel address: x + (y/8)*WIDTH, bit 7-(y mod 8)
    always_comb
    begin
        pix_in_range = ({1'b0, item.pixel_x} < 9'(pfr_pkg::WIDTH))
                    && ({1'b0, item.pixel_y} < 9'(pfr_pkg::ROW_LIMIT));
        pix_addr     = pfr_pkg::ADDR_W'(item.pixel_x)
                     + pfr_pkg::ADDR_W'(item.pixel_y[7:3])
                     * pfr_pkg::ADDR_W'(pfr_pkg::WIDTH);
        pix_mask     = 8'h80 >> item.pixel_y[2:0];
    end

    // stream byte for the current position
    always_comb
    begin
        data_addr = pfr_pkg::ADDR_W'(page_reg) * pfr_pkg::ADDR_W'(pfr_pkg::WIDTH)
                  + pfr_pkg::ADDR_W'(pos_reg - pfr_pkg::POS_W'(pfr_pkg::CMD_COUNT));
        case (pos_reg)
            pfr_pkg::POS_PAGE_CMD:
                cmd_byte = page_cmd_base_reg
                         | {5'b0, pfr_pkg::PAGE_TOP
                                  - pfr_pkg::PAGE_FIELD_W'(page_reg)};
            pfr_pkg::POS_COL_LOW_CMD:
                cmd_byte = col_low_cmd_base_reg | (start_column_reg & pfr_pkg::NIBBLE_MASK);
            pfr_pkg::POS_COL_HI_CMD:
                cmd_byte = col_hi_cmd_base_reg
                         | ((start_column_reg >> 4) & pfr_pkg::NIBBLE_MASK);
            pfr_pkg::POS_RMW_CMD:
                cmd_byte = rmw_cmd_reg;
            default:
                cmd_byte = 8'h00;
        endcase
    end

    // advance the refresh walk
    always_comb
    begin
        wrap_page = (pos_reg == pfr_pkg::POS_LAST);
        frame_end = wrap_page && (page_reg == pfr_pkg::PAGE_W'(pfr_pkg::PAGES - 1));
        if (wrap_page)
        begin
            pos_next  = '0;
            page_next = frame_end ? '0 : page_reg + pfr_pkg::PAGE_W'(1);
        end
        else
        begin
            pos_next  = pos_reg + pfr_pkg::POS_W'(1);
            page_next = page_reg;
        end
    end

    // memory port selection
    always_comb
    begin
        rd_addr = item.action ? data_addr : pix_addr;
        mem_we  = 1'b0;
        wr_addr = pix_addr_reg;
        wr_data = pix_on_reg ? (rd_data_reg | pix_mask_reg) : (rd_data_reg & ~pix_mask_reg);
        if (state_reg == S_CLEAR)
        begin
            mem_we  = 1'b1;
            wr_addr = clr_addr_reg;
            wr_data = 8'h00;
        end
        else if (state_reg == S_PIX)
        begin
            mem_we = pix_ok_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            frame_mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= frame_mem[rd_addr];
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_CLEAR:
                if (clr_addr_reg == pfr_pkg::ADDR_W'(pfr_pkg::DEPTH - 1))
                begin
                    state_next = S_IDLE;
                end
            S_IDLE:
                if (accept)
                begin
                    state_next = item.action ? S_EMIT : S_PIX;
                end
            S_PIX:   state_next = S_IDLE;
            S_EMIT:  state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_CLEAR;
            clr_addr_reg     <= '0;
            page_reg         <= '0;
            pos_reg          <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == S_CLEAR)
            begin
                clr_addr_reg <= clr_addr_reg + pfr_pkg::ADDR_W'(1);
            end
            if (accept && item.action)
            begin
                page_reg <= page_next;
                pos_reg  <= pos_next;
            end
            // drop the byte once taken, load a fresh one after its memory read
            if (state_reg == S_EMIT)
            begin
                result_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                result_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_column_reg     <= pfr_pkg::RST_START_COLUMN;
            page_cmd_base_reg    <= pfr_pkg::RST_PAGE_CMD_BASE;
            col_low_cmd_base_reg <= pfr_pkg::RST_COL_LOW_CMD_BASE;
            col_hi_cmd_base_reg  <= pfr_pkg::RST_COL_HI_CMD_BASE;
            rmw_cmd_reg          <= pfr_pkg::RST_RMW_CMD;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                pfr_pkg::REG_START_COLUMN:     start_column_reg     <= cfg.data;
                pfr_pkg::REG_PAGE_CMD_BASE:    page_cmd_base_reg    <= cfg.data;
                pfr_pkg::REG_COL_LOW_CMD_BASE: col_low_cmd_base_reg <= cfg.data;
                pfr_pkg::REG_COL_HI_CMD_BASE:  col_hi_cmd_base_reg  <= cfg.data;
                pfr_pkg::REG_RMW_CMD:          rmw_cmd_reg          <= cfg.data;
                default:                       ;
            endcase
        end
    end

    // hold request details for the S_PIX or S_EMIT state
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            pix_addr_reg  <= pix_addr;
            pix_ok_reg    <= pix_in_range;
            pix_mask_reg  <= pix_mask;
            pix_on_reg    <= item.pixel_on;
            cmd_byte_reg  <= cmd_byte;
            emit_data_reg <= (pos_reg > pfr_pkg::POS_RMW_CMD);
            emit_last_reg <= frame_end;
        end
        if (state_reg == S_EMIT)
        begin
            result_reg.out_byte   <= emit_data_reg ? rd_data_reg : cmd_byte_reg;
            result_reg.is_data    <= emit_data_reg;
            result_reg.frame_last <= emit_last_reg;
        end
    end

endmodule

`default_nettype wire

[rtl/core/pfr_checker.sv]
`timescale 1ns / 1ps
`default_nettype none

`include "page_framebuffer_refresh_defines.svh"

module pfr_checker (
    input wire       clk,
    input wire       rst_n,
    input wire       item_valid,
    input wire       item_ready,
    input wire       item_action,
    input wire       result_valid,
    input wire       result_ready,
    input wire       result_is_data,
    input wire       result_frame_last
);

    // a stalled byte stays offered
    `PFR_ASSERT_NEXT(a_result_hold, result_valid && !result_ready, result_valid, "result dropped while stalled")

    // only data bytes close a frame
    `PFR_ASSERT_IMPLY(a_last_is_data, result_valid && result_frame_last, result_is_data, "frame_last on a command byte")

    // every new byte comes from an earlier accepted stream request
    `PFR_ASSERT_IMPLY(a_result_cause, $rose(result_valid), $past(item_valid && item_ready && item_action, 2), "result without stream request")

    // no request is taken as reset releases into the clearing pass
    `PFR_ASSERT_IMPLY(a_clear_blocks, $rose(rst_n), !item_ready, "request taken during clearing pass")

endmodule

bind page_framebuffer_refresh pfr_checker u_pfr_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .item_valid        (item.valid),
    .item_ready        (item.ready),
    .item_action       (item.action),
    .result_valid      (result.valid),
    .result_ready      (result.ready),
    .result_is_data    (result.is_data),
    .result_frame_last (result.frame_last)
);

`default_nettype wire
